[sv/scle_pkg.sv]
// scle_pkg: shared constants, codes and the item descriptor type
// for the serial command line editor core; no dependencies

package scle_pkg;

  localparam int LINE_SIZE_DEF = 64;

  // input selector codes
  localparam logic [1:0] FUNC_RX   = 2'd0;
  localparam logic [1:0] FUNC_TX   = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // line status codes
  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DEL  = 3'd2;
  localparam logic [2:0] ST_ESC  = 3'd3;
  localparam logic [2:0] ST_OVF  = 3'd4;

  // line-ending modes
  localparam logic [1:0] MODE_CR   = 2'd0;
  localparam logic [1:0] MODE_LF   = 2'd1;
  localparam logic [1:0] MODE_CRLF = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // one decoded item: up to three result bytes sharing one status
  typedef struct packed {
    logic [2:0] status;
    logic [1:0] last_k;    // index of the final result
    logic       has_byte;
    logic       from_mem;  // first byte comes from the buffer read port
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } scle_desc_t;

endpackage

[sv/scle_buf.sv]
// scle_buf: line buffer memory, one write port and one registered read port
// depends on nothing but its parameters

module scle_buf #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/scle_edit.sv]
// scle_edit: line state, item decode, buffer write/read control and the
// clearing pass after reset; uses scle_pkg

module scle_edit #(
  parameter int LINE_SIZE = scle_pkg::LINE_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [1:0]                             in_func,
  input  logic [7:0]                             in_byte,
  input  logic [6:0]                             in_index,
  input  logic                                   emit_free,
  output logic                                   push,
  output scle_pkg::scle_desc_t                   desc,
  output logic                                   mem_we,
  output logic [$clog2(LINE_SIZE+1)-1:0]         mem_waddr,
  output logic [7:0]                             mem_wdata,
  output logic                                   mem_re,
  output logic [$clog2(LINE_SIZE+1)-1:0]         mem_raddr
);

  localparam int AW = $clog2(LINE_SIZE + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(LINE_SIZE);

  logic [AW-1:0] pos_r, pos_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    cur_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_done_r;

  logic          acc;
  logic          item_we;
  logic [7:0]    item_wdata;
  logic          rd_in_range;
  logic [1:0]    nl_mode;
  logic [1:0]    nl_last;
  logic [7:0]    nl_b0;
  logic [7:0]    nl_b1;
  scle_pkg::scle_desc_t d;

  assign in_tready   = clr_done_r & emit_free;
  assign acc         = in_tvalid & in_tready;
  assign rd_in_range = (32'(in_index) <= LINE_SIZE);

  // line-ending mode tracking from the last two received bytes
  always_comb begin
    mode_nxt = mode_r;
    if (cur_r == scle_pkg::CH_CR && in_byte == scle_pkg::CH_CR) begin
      mode_nxt = scle_pkg::MODE_CR;
    end else if (cur_r == scle_pkg::CH_LF && in_byte == scle_pkg::CH_LF) begin
      mode_nxt = scle_pkg::MODE_LF;
    end else if (cur_r == scle_pkg::CH_CR && in_byte == scle_pkg::CH_LF) begin
      mode_nxt = scle_pkg::MODE_CRLF;
    end
  end

  // LF translated by mode: received items use the updated mode
  always_comb begin
    nl_mode = (in_func == scle_pkg::FUNC_RX) ? mode_nxt : mode_r;
    nl_last = 2'd0;
    nl_b0   = scle_pkg::CH_LF;
    nl_b1   = scle_pkg::CH_LF;
    if (nl_mode == scle_pkg::MODE_CRLF) begin
      nl_last = 2'd1;
      nl_b0   = scle_pkg::CH_CR;
    end else if (nl_mode == scle_pkg::MODE_CR) begin
      nl_b0   = scle_pkg::CH_CR;
    end
  end

  always_comb begin
    d          = '0;
    d.status   = scle_pkg::ST_WAIT;
    pos_nxt    = pos_r;
    item_we    = 1'b0;
    item_wdata = scle_pkg::CH_NUL;
    unique case (in_func)
      scle_pkg::FUNC_RX: begin
        case (in_byte) inside
          scle_pkg::CH_NUL: begin
          end
          scle_pkg::CH_BS: begin
            if (pos_r != '0) begin
              pos_nxt    = pos_r - AW'(1);
              d.last_k   = 2'd2;
              d.has_byte = 1'b1;
              d.b0       = scle_pkg::CH_BS;
              d.b1       = scle_pkg::CH_SP;
              d.b2       = scle_pkg::CH_BS;
            end
          end
          scle_pkg::CH_CR, scle_pkg::CH_LF: begin
            if (in_byte == scle_pkg::CH_LF || mode_nxt == scle_pkg::MODE_CR) begin
              item_we    = 1'b1;
              pos_nxt    = '0;
              d.status   = scle_pkg::ST_EXEC;
              d.last_k   = nl_last;
              d.has_byte = 1'b1;
              d.b0       = nl_b0;
              d.b1       = nl_b1;
            end
          end
          scle_pkg::CH_DEL: begin
            pos_nxt  = '0;
            d.status = scle_pkg::ST_DEL;
          end
          scle_pkg::CH_ESC: begin
            pos_nxt  = '0;
            d.status = scle_pkg::ST_ESC;
          end
          default: begin
            if (pos_r < LAST_POS) begin
              item_we    = 1'b1;
              item_wdata = in_byte;
              pos_nxt    = pos_r + AW'(1);
              d.has_byte = 1'b1;
              d.b0       = in_byte;
            end else begin
              pos_nxt  = '0;
              d.status = scle_pkg::ST_OVF;
            end
          end
        endcase
      end
      scle_pkg::FUNC_TX: begin
        d.has_byte = 1'b1;
        if (in_byte == scle_pkg::CH_LF) begin
          d.last_k = nl_last;
          d.b0     = nl_b0;
          d.b1     = nl_b1;
        end else begin
          d.b0 = in_byte;
        end
      end
      scle_pkg::FUNC_READ: begin
        d.has_byte = 1'b1;
        d.from_mem = rd_in_range;
      end
      scle_pkg::FUNC_NONE: begin
      end
    endcase
  end

  assign push = acc;
  assign desc = d;

  // clearing pass owns the write port until done
  always_comb begin
    if (!clr_done_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = scle_pkg::CH_NUL;
    end else begin
      mem_we    = acc & item_we;
      mem_waddr = pos_r;
      mem_wdata = item_wdata;
    end
  end

  assign mem_re    = acc & (in_func == scle_pkg::FUNC_READ) & rd_in_range;
  assign mem_raddr = AW'(in_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      mode_r     <= scle_pkg::MODE_CR;
      cur_r      <= scle_pkg::CH_NUL;
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_POS) begin
          clr_done_r <= 1'b1;
        end
      end
      if (acc && in_func == scle_pkg::FUNC_RX) begin
        cur_r  <= in_byte;
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

endmodule

[sv/scle_emit.sv]
// scle_emit: holds one decoded item and sends its results one per cycle
// through the output register while the output is not stalled; uses scle_pkg

module scle_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  scle_pkg::scle_desc_t desc,
  input  logic [7:0]           rd_data,
  output logic                 emit_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast
);

  scle_pkg::scle_desc_t desc_r;
  logic       busy_r;
  logic [1:0] k_r;
  logic       ov_r;
  logic [2:0] o_status_r;
  logic [7:0] o_byte_r;
  logic       o_valid_r;
  logic       o_last_r;

  logic       out_adv;
  logic       fire;
  logic       done;
  logic [7:0] sel_byte;

  assign out_adv   = ~ov_r | out_tready;
  assign fire      = busy_r & out_adv;
  assign done      = fire & (k_r == desc_r.last_k);
  assign emit_free = ~busy_r | done;

  always_comb begin
    case (k_r)
      2'd0:    sel_byte = desc_r.from_mem ? rd_data : desc_r.b0;
      2'd1:    sel_byte = desc_r.b1;
      default: sel_byte = desc_r.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (push) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (fire) begin
        k_r <= k_r + 2'd1;
      end
      if (fire) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      desc_r <= desc;
    end
    if (fire) begin
      o_status_r <= desc_r.status;
      o_byte_r   <= desc_r.has_byte ? sel_byte : scle_pkg::CH_NUL;
      o_valid_r  <= desc_r.has_byte;
      o_last_r   <= (k_r == desc_r.last_k);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, o_valid_r, o_byte_r, o_status_r};
  assign out_tlast  = o_last_r;

endmodule

[sv/serial_command_line_editor_core.sv]
// serial_command_line_editor_core: top level of the terminal line editor
// depends on scle_pkg, scle_buf, scle_edit and scle_emit
//
//  channel | dir | fields (low bit up)
//  in_     | in  | tdata: data_byte[7:0], read_index[14:8]; tuser: func[1:0]
//  out_    | out | tdata: line_status[2:0], out_byte[10:3], out_valid[11]; tlast: last
//
// an item is accepted and its results leave the output register one per cycle
// while the output is not stalled: one result for most items, two for a CR LF
// newline, three for the backspace echo; the one output register sets that rate.
// after reset the buffer is zeroed one entry a cycle, all LINE_SIZE+1 entries,
// with in_tready low. a stalled output holds the item and in_tready drops.

module serial_command_line_editor_core #(
  parameter int LINE_SIZE = scle_pkg::LINE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], read_index[14:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // line_status[2:0], out_byte[10:3], out_valid[11]
  output logic        out_tlast
);

  localparam int AW = $clog2(LINE_SIZE + 1);

  logic                 emit_free;
  logic                 push;
  scle_pkg::scle_desc_t desc;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [7:0]           mem_rdata;

  scle_edit #(
    .LINE_SIZE (LINE_SIZE)
  ) u_edit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_index  (in_tdata[14:8]),
    .emit_free (emit_free),
    .push      (push),
    .desc      (desc),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr)
  );

  scle_buf #(
    .DEPTH (LINE_SIZE + 1),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  scle_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .desc       (desc),
    .rd_data    (mem_rdata),
    .emit_free  (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
